// ===== rtl/rsnh_pkg.sv =====
// shared types and constants of the ray sphere nearest hit unit
package rsnh_pkg;

    localparam int COORD_W = 24;
    localparam int RAD_W   = 23;
    localparam int KIND_W  = 4;
    localparam int SLOT_W  = 5;
    localparam int DIST_W  = 24;

    localparam int OC_W    = COORD_W + 1;
    localparam int MUL_W   = 26;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int LIMB_W  = 25;
    localparam int ACC_W   = 101;
    localparam int A_W     = 48;
    localparam int H_W     = 51;
    localparam int HM_W    = 49;
    localparam int C_W     = 50;
    localparam int DISC_W  = 98;
    localparam int ROOT_W  = 49;
    localparam int SQR_W   = 52;
    localparam int CNT_W   = 6;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_25 = 2'd1;
    localparam logic [1:0] SH_50 = 2'd2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam logic [Q_PTR_W:0] Q_CNT_FULL = 2'd2;

    typedef struct packed {
        logic                      req_type;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic [RAD_W-1:0]          radius;
        logic [KIND_W-1:0]         kind;
        logic                      present;
    } req_item_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [KIND_W-1:0] hit_kind;
        logic [DIST_W-1:0] hit_distance;
    } res_item_t;

    typedef struct packed {
        logic      is_cast;
        logic      zero_dir;
        req_item_t item;
    } cmd_t;

endpackage

// ===== rtl/rsnh_front.sv =====
// request intake: classifies each transfer and holds it for the queue
module rsnh_front #(
    parameter int MAX_SPHERES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  rsnh_pkg::req_item_t req,
    output logic                push_valid,
    output rsnh_pkg::cmd_t      push_cmd,
    input  logic                q_full
);

    logic           hold_valid_reg;
    logic           hold_valid_next;
    rsnh_pkg::cmd_t hold_cmd_reg;
    rsnh_pkg::cmd_t hold_cmd_next;
    logic           accept;
    logic           keep;

    assign req_stall  = hold_valid_reg && q_full;
    assign accept     = req_valid && !req_stall;
    assign push_valid = hold_valid_reg && !q_full;
    assign push_cmd   = hold_cmd_reg;

    // writes beyond the table are dropped here
    assign keep = (req.req_type == rsnh_pkg::REQ_CAST) || (32'(req.slot) < MAX_SPHERES);

    always_comb
    begin
        hold_cmd_next          = hold_cmd_reg;
        hold_valid_next        = hold_valid_reg && q_full;
        if (accept)
        begin
            hold_valid_next        = keep;
            hold_cmd_next.is_cast  = (req.req_type == rsnh_pkg::REQ_CAST);
            hold_cmd_next.zero_dir = (req.dir_x == '0) && (req.dir_y == '0) && (req.dir_z == '0);
            hold_cmd_next.item     = req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

// ===== rtl/rsnh_queue.sv =====
// short command queue between intake and execution
module rsnh_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  rsnh_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           head_valid,
    output rsnh_pkg::cmd_t head_cmd,
    input  logic           pop
);

    rsnh_pkg::cmd_t                 entry_reg [rsnh_pkg::Q_DEPTH];
    logic [rsnh_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [rsnh_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [rsnh_pkg::Q_PTR_W:0]     cnt_reg;
    logic [rsnh_pkg::Q_PTR_W:0]     cnt_next;

    assign full       = (cnt_reg == rsnh_pkg::Q_CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push_valid && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push_valid && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/rsnh_back.sv =====
// execution unit: sphere table, shared multiplier, square root and divider
module rsnh_back #(
    parameter int MAX_SPHERES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  rsnh_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_stall,
    output rsnh_pkg::res_item_t res
);

    localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SPHERES - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_A    = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_READ = 4'd3;
    localparam logic [3:0] S_H    = 4'd4;
    localparam logic [3:0] S_C    = 4'd5;
    localparam logic [3:0] S_D    = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_SAT  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_UPD  = 4'd10;
    localparam logic [3:0] S_NEXT = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    // sphere table
    logic signed [rsnh_pkg::COORD_W-1:0] cx_mem   [MAX_SPHERES];
    logic signed [rsnh_pkg::COORD_W-1:0] cy_mem   [MAX_SPHERES];
    logic signed [rsnh_pkg::COORD_W-1:0] cz_mem   [MAX_SPHERES];
    logic [rsnh_pkg::RAD_W-1:0]          rad_mem  [MAX_SPHERES];
    logic [rsnh_pkg::KIND_W-1:0]         kind_mem [MAX_SPHERES];
    logic [MAX_SPHERES-1:0]              present_reg;

    logic signed [rsnh_pkg::COORD_W-1:0] rd_cx_reg;
    logic signed [rsnh_pkg::COORD_W-1:0] rd_cy_reg;
    logic signed [rsnh_pkg::COORD_W-1:0] rd_cz_reg;
    logic [rsnh_pkg::RAD_W-1:0]          rd_rad_reg;
    logic [rsnh_pkg::KIND_W-1:0]         rd_kind_reg;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic                 rd_en;

    // control
    logic [3:0]                   state_reg, state_next;
    logic [3:0]                   k_reg, k_next;
    logic [rsnh_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic                         prod_vld_reg;
    logic                         found_reg, found_next;
    logic                         res_valid_reg, res_valid_next;
    logic signed [rsnh_pkg::ACC_W-1:0] acc_reg, acc_next;

    // working registers
    logic signed [rsnh_pkg::COORD_W-1:0] org_x_reg, org_x_next;
    logic signed [rsnh_pkg::COORD_W-1:0] org_y_reg, org_y_next;
    logic signed [rsnh_pkg::COORD_W-1:0] org_z_reg, org_z_next;
    logic signed [rsnh_pkg::COORD_W-1:0] dx_reg, dx_next;
    logic signed [rsnh_pkg::COORD_W-1:0] dy_reg, dy_next;
    logic signed [rsnh_pkg::COORD_W-1:0] dz_reg, dz_next;
    logic signed [rsnh_pkg::OC_W-1:0]    ox_reg, ox_next;
    logic signed [rsnh_pkg::OC_W-1:0]    oy_reg, oy_next;
    logic signed [rsnh_pkg::OC_W-1:0]    oz_reg, oz_next;
    logic [rsnh_pkg::RAD_W-1:0]          r_reg, r_next;
    logic [rsnh_pkg::KIND_W-1:0]         kind_cur_reg, kind_cur_next;
    logic [rsnh_pkg::A_W-1:0]            a_reg, a_next;
    logic signed [rsnh_pkg::H_W-1:0]     h_reg, h_next;
    logic [rsnh_pkg::C_W-1:0]            c_reg, c_next;
    logic [rsnh_pkg::HM_W-1:0]           hm_reg, hm_next;
    logic [rsnh_pkg::DISC_W-1:0]         sq_rad_reg, sq_rad_next;
    logic [rsnh_pkg::SQR_W-1:0]          sq_rem_reg, sq_rem_next;
    logic [rsnh_pkg::ROOT_W-1:0]         root_reg, root_next;
    logic [rsnh_pkg::HM_W-1:0]           num_reg, num_next;
    logic [rsnh_pkg::HM_W-1:0]           drem_reg, drem_next;
    logic [rsnh_pkg::DIST_W-1:0]         dv_reg, dv_next;
    logic [rsnh_pkg::DIST_W-1:0]         quo_reg, quo_next;
    logic [rsnh_pkg::DIST_W-1:0]         t_reg, t_next;
    logic [rsnh_pkg::DIST_W-1:0]         best_t_reg, best_t_next;
    logic [rsnh_pkg::SLOT_W-1:0]         best_slot_reg, best_slot_next;
    logic [rsnh_pkg::KIND_W-1:0]         best_kind_reg, best_kind_next;
    rsnh_pkg::res_item_t                 res_reg, res_next;

    // shared multiplier
    logic signed [rsnh_pkg::MUL_W-1:0]   mx, my;
    logic signed [rsnh_pkg::PROD_W-1:0]  prod, prod_reg;
    logic [1:0]                          sh_sel, sh_reg;
    logic [3:0]                          last_k;
    logic                                mac_state;
    logic                                issue;
    logic                                drain;
    logic signed [rsnh_pkg::ACC_W-1:0]   prod_ext;
    logic signed [rsnh_pkg::ACC_W-1:0]   prod_sh;
    logic signed [rsnh_pkg::ACC_W-1:0]   acc_sum;
    logic signed [rsnh_pkg::H_W-1:0]     neg_h;

    // iteration steps
    logic [rsnh_pkg::SQR_W-1:0]          rem_sh, trial, sq_rem_step;
    logic                                sq_ge;
    logic [rsnh_pkg::ROOT_W-1:0]         root_step;
    logic [rsnh_pkg::HM_W:0]             dr_sh;
    logic                                dv_ge;
    logic [rsnh_pkg::HM_W-1:0]           drem_step;
    logic [rsnh_pkg::DIST_W-1:0]         quo_step;
    logic                                sat;

    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign wr_en   = q_pop && !q_cmd.is_cast;
    assign wr_addr = IDX_W'(q_cmd.item.slot);
    assign rd_en   = (state_reg == S_SCAN) && present_reg[idx_reg];

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cx_mem[wr_addr]   <= q_cmd.item.pos_x;
            cy_mem[wr_addr]   <= q_cmd.item.pos_y;
            cz_mem[wr_addr]   <= q_cmd.item.pos_z;
            rad_mem[wr_addr]  <= q_cmd.item.radius;
            kind_mem[wr_addr] <= q_cmd.item.kind;
        end
        if (rd_en)
        begin
            rd_cx_reg   <= cx_mem[idx_reg];
            rd_cy_reg   <= cy_mem[idx_reg];
            rd_cz_reg   <= cz_mem[idx_reg];
            rd_rad_reg  <= rad_mem[idx_reg];
            rd_kind_reg <= kind_mem[idx_reg];
        end
    end

    // operand selection for the shared multiplier
    assign mac_state = (state_reg == S_A) || (state_reg == S_H) ||
                       (state_reg == S_C) || (state_reg == S_D);

    always_comb
    begin
        mx     = '0;
        my     = '0;
        sh_sel = rsnh_pkg::SH_0;
        last_k = 4'd0;
        case (state_reg)
            S_A:
            begin
                last_k = 4'd3;
                case (k_reg)
                    4'd0:    begin mx = rsnh_pkg::MUL_W'(dx_reg); my = rsnh_pkg::MUL_W'(dx_reg); end
                    4'd1:    begin mx = rsnh_pkg::MUL_W'(dy_reg); my = rsnh_pkg::MUL_W'(dy_reg); end
                    4'd2:    begin mx = rsnh_pkg::MUL_W'(dz_reg); my = rsnh_pkg::MUL_W'(dz_reg); end
                    default: ;
                endcase
            end
            S_H:
            begin
                last_k = 4'd3;
                case (k_reg)
                    4'd0:    begin mx = rsnh_pkg::MUL_W'(ox_reg); my = rsnh_pkg::MUL_W'(dx_reg); end
                    4'd1:    begin mx = rsnh_pkg::MUL_W'(oy_reg); my = rsnh_pkg::MUL_W'(dy_reg); end
                    4'd2:    begin mx = rsnh_pkg::MUL_W'(oz_reg); my = rsnh_pkg::MUL_W'(dz_reg); end
                    default: ;
                endcase
            end
            S_C:
            begin
                last_k = 4'd4;
                case (k_reg)
                    4'd0:    begin mx = rsnh_pkg::MUL_W'(ox_reg); my = rsnh_pkg::MUL_W'(ox_reg); end
                    4'd1:    begin mx = rsnh_pkg::MUL_W'(oy_reg); my = rsnh_pkg::MUL_W'(oy_reg); end
                    4'd2:    begin mx = rsnh_pkg::MUL_W'(oz_reg); my = rsnh_pkg::MUL_W'(oz_reg); end
                    4'd3:    begin mx = rsnh_pkg::MUL_W'(r_reg);  my = -rsnh_pkg::MUL_W'(r_reg); end
                    default: ;
                endcase
            end
            S_D:
            begin
                // disc = hm*hm - a*c from 25-bit limbs
                last_k = 4'd8;
                case (k_reg)
                    4'd0:
                    begin
                        mx = rsnh_pkg::MUL_W'(hm_reg[24:0]);
                        my = rsnh_pkg::MUL_W'(hm_reg[24:0]);
                    end
                    4'd1:
                    begin
                        mx = rsnh_pkg::MUL_W'(hm_reg[24:0]);
                        my = rsnh_pkg::MUL_W'(hm_reg[48:25]);
                        sh_sel = rsnh_pkg::SH_25;
                    end
                    4'd2:
                    begin
                        mx = rsnh_pkg::MUL_W'(hm_reg[48:25]);
                        my = rsnh_pkg::MUL_W'(hm_reg[24:0]);
                        sh_sel = rsnh_pkg::SH_25;
                    end
                    4'd3:
                    begin
                        mx = rsnh_pkg::MUL_W'(hm_reg[48:25]);
                        my = rsnh_pkg::MUL_W'(hm_reg[48:25]);
                        sh_sel = rsnh_pkg::SH_50;
                    end
                    4'd4:
                    begin
                        mx = rsnh_pkg::MUL_W'(a_reg[24:0]);
                        my = -rsnh_pkg::MUL_W'(c_reg[24:0]);
                    end
                    4'd5:
                    begin
                        mx = rsnh_pkg::MUL_W'(a_reg[24:0]);
                        my = -rsnh_pkg::MUL_W'(c_reg[49:25]);
                        sh_sel = rsnh_pkg::SH_25;
                    end
                    4'd6:
                    begin
                        mx = rsnh_pkg::MUL_W'(a_reg[47:25]);
                        my = -rsnh_pkg::MUL_W'(c_reg[24:0]);
                        sh_sel = rsnh_pkg::SH_25;
                    end
                    4'd7:
                    begin
                        mx = rsnh_pkg::MUL_W'(a_reg[47:25]);
                        my = -rsnh_pkg::MUL_W'(c_reg[49:25]);
                        sh_sel = rsnh_pkg::SH_50;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign issue = mac_state && (k_reg != last_k);
    assign drain = mac_state && (k_reg == last_k);
    assign prod  = mx * my;

    assign prod_ext = rsnh_pkg::ACC_W'(prod_reg);

    always_comb
    begin
        case (sh_reg)
            rsnh_pkg::SH_25: prod_sh = prod_ext <<< rsnh_pkg::LIMB_W;
            rsnh_pkg::SH_50: prod_sh = prod_ext <<< (2 * rsnh_pkg::LIMB_W);
            default:         prod_sh = prod_ext;
        endcase
    end

    assign acc_sum = prod_vld_reg ? (acc_reg + prod_sh) : acc_reg;
    assign neg_h   = -h_reg;

    // one root bit per step
    assign rem_sh      = {sq_rem_reg[rsnh_pkg::SQR_W-3:0],
                          sq_rad_reg[rsnh_pkg::DISC_W-1:rsnh_pkg::DISC_W-2]};
    assign trial       = {1'b0, root_reg, 2'b01};
    assign sq_ge       = (rem_sh >= trial);
    assign sq_rem_step = sq_ge ? (rem_sh - trial) : rem_sh;
    assign root_step   = {root_reg[rsnh_pkg::ROOT_W-2:0], sq_ge};

    // one quotient bit per step
    assign dr_sh     = {drem_reg, dv_reg[rsnh_pkg::DIST_W-1]};
    assign dv_ge     = (dr_sh >= {2'b00, a_reg});
    assign drem_step = dv_ge ? rsnh_pkg::HM_W'(dr_sh - {2'b00, a_reg})
                             : rsnh_pkg::HM_W'(dr_sh);
    assign quo_step  = {quo_reg[rsnh_pkg::DIST_W-2:0], dv_ge};

    // quotient would reach 2^24
    assign sat = ({15'd0, num_reg} >= {a_reg, 16'd0});

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        res_valid_next = res_valid_reg && res_stall;
        acc_next       = acc_reg;
        org_x_next     = org_x_reg;
        org_y_next     = org_y_reg;
        org_z_next     = org_z_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        r_next         = r_reg;
        kind_cur_next  = kind_cur_reg;
        a_next         = a_reg;
        h_next         = h_reg;
        c_next         = c_reg;
        hm_next        = hm_reg;
        sq_rad_next    = sq_rad_reg;
        sq_rem_next    = sq_rem_reg;
        root_next      = root_reg;
        num_next       = num_reg;
        drem_next      = drem_reg;
        dv_next        = dv_reg;
        quo_next       = quo_reg;
        t_next         = t_reg;
        best_t_next    = best_t_reg;
        best_slot_next = best_slot_reg;
        best_kind_next = best_kind_reg;
        res_next       = res_reg;

        if (mac_state)
        begin
            if (drain)
            begin
                k_next   = 4'd0;
                acc_next = '0;
            end
            else
            begin
                k_next   = k_reg + 1'b1;
                acc_next = acc_sum;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_cmd.is_cast)
                begin
                    org_x_next     = q_cmd.item.pos_x;
                    org_y_next     = q_cmd.item.pos_y;
                    org_z_next     = q_cmd.item.pos_z;
                    dx_next        = q_cmd.item.dir_x;
                    dy_next        = q_cmd.item.dir_y;
                    dz_next        = q_cmd.item.dir_z;
                    found_next     = 1'b0;
                    best_t_next    = '0;
                    best_slot_next = '0;
                    best_kind_next = '0;
                    idx_next       = '0;
                    state_next     = q_cmd.zero_dir ? S_DONE : S_A;
                end
            end
            S_A:
            begin
                if (drain)
                begin
                    a_next     = acc_sum[rsnh_pkg::A_W-1:0];
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (present_reg[idx_reg])
                begin
                    state_next = S_READ;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_READ:
            begin
                ox_next       = rsnh_pkg::OC_W'(org_x_reg) - rsnh_pkg::OC_W'(rd_cx_reg);
                oy_next       = rsnh_pkg::OC_W'(org_y_reg) - rsnh_pkg::OC_W'(rd_cy_reg);
                oz_next       = rsnh_pkg::OC_W'(org_z_reg) - rsnh_pkg::OC_W'(rd_cz_reg);
                r_next        = rd_rad_reg;
                kind_cur_next = rd_kind_reg;
                state_next    = S_H;
            end
            S_H:
            begin
                if (drain)
                begin
                    h_next     = acc_sum[rsnh_pkg::H_W-1:0];
                    state_next = S_C;
                end
            end
            S_C:
            begin
                if (drain)
                begin
                    c_next  = acc_sum[rsnh_pkg::C_W-1:0];
                    hm_next = neg_h[rsnh_pkg::HM_W-1:0];
                    // pointing away or origin inside
                    if ((!h_reg[rsnh_pkg::H_W-1] && (h_reg != '0)) ||
                        acc_sum[rsnh_pkg::ACC_W-1])
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        state_next = S_D;
                    end
                end
            end
            S_D:
            begin
                if (drain)
                begin
                    if (acc_sum[rsnh_pkg::ACC_W-1])
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        sq_rad_next = acc_sum[rsnh_pkg::DISC_W-1:0];
                        sq_rem_next = '0;
                        root_next   = '0;
                        cnt_next    = rsnh_pkg::CNT_W'(rsnh_pkg::ROOT_W - 1);
                        state_next  = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                sq_rem_next = sq_rem_step;
                root_next   = root_step;
                sq_rad_next = sq_rad_reg << 2;
                if (cnt_reg == '0)
                begin
                    num_next   = hm_reg - root_step;
                    state_next = S_SAT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_SAT:
            begin
                if (sat)
                begin
                    t_next     = rsnh_pkg::DIST_MAX;
                    state_next = S_UPD;
                end
                else
                begin
                    drem_next  = {16'd0, num_reg[rsnh_pkg::HM_W-1:16]};
                    dv_next    = {num_reg[15:0], 8'd0};
                    quo_next   = '0;
                    cnt_next   = rsnh_pkg::CNT_W'(rsnh_pkg::DIST_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                drem_next = drem_step;
                dv_next   = dv_reg << 1;
                quo_next  = quo_step;
                if (cnt_reg == '0)
                begin
                    t_next     = quo_step;
                    state_next = S_UPD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_UPD:
            begin
                // strict less-than keeps the earliest slot on ties
                if (!found_reg || (t_reg < best_t_reg))
                begin
                    found_next     = 1'b1;
                    best_t_next    = t_reg;
                    best_slot_next = rsnh_pkg::SLOT_W'(idx_reg);
                    best_kind_next = kind_cur_reg;
                end
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.hit          = found_reg;
                    res_next.hit_slot     = found_reg ? best_slot_reg : '0;
                    res_next.hit_kind     = found_reg ? best_kind_reg : '0;
                    res_next.hit_distance = found_reg ? best_t_reg : '0;
                    res_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            prod_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            acc_reg       <= '0;
            present_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            prod_vld_reg  <= issue;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            acc_reg       <= acc_next;
            if (wr_en)
            begin
                present_reg[wr_addr] <= q_cmd.item.present;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod;
        sh_reg        <= sh_sel;
        org_x_reg     <= org_x_next;
        org_y_reg     <= org_y_next;
        org_z_reg     <= org_z_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        dz_reg        <= dz_next;
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
        oz_reg        <= oz_next;
        r_reg         <= r_next;
        kind_cur_reg  <= kind_cur_next;
        a_reg         <= a_next;
        h_reg         <= h_next;
        c_reg         <= c_next;
        hm_reg        <= hm_next;
        sq_rad_reg    <= sq_rad_next;
        sq_rem_reg    <= sq_rem_next;
        root_reg      <= root_next;
        num_reg       <= num_next;
        drem_reg      <= drem_next;
        dv_reg        <= dv_next;
        quo_reg       <= quo_next;
        t_reg         <= t_next;
        best_t_reg    <= best_t_next;
        best_slot_reg <= best_slot_next;
        best_kind_reg <= best_kind_next;
        res_reg       <= res_next;
    end

`ifndef SYNTH
    a_res_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside the done state");

    a_scan_dir_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (a_reg != '0))
        else $error("scanning with a zero direction");

    a_root_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SAT) |-> (root_reg <= hm_reg))
        else $error("square root exceeds -h");

    a_div_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ({1'b0, drem_reg} < {2'b00, a_reg}))
        else $error("divider remainder out of range");
`endif

endmodule

// ===== rtl/ray_sphere_nearest_hit_unit.sv =====
// top level of the ray sphere nearest hit unit
// a write passes through the intake hold register and the queue into the table; it gives no result
// a cast tests each present sphere in slot order and skips empty slots, using the shared 26x26 multiplier,
// the 49-step square root and the 24-step divider
// one item is executed at a time; the queue and output register let intake and delivery run on
// reset clears the present marks and all control at once; the table needs no clearing pass
module ray_sphere_nearest_hit_unit #(
    parameter int MAX_SPHERES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  rsnh_pkg::req_item_t req,
    output logic                res_valid,
    input  logic                res_stall,
    output rsnh_pkg::res_item_t res
);

    // intake to queue
    logic           push_valid;
    rsnh_pkg::cmd_t push_cmd;
    logic           q_full;

    // queue to execution
    logic           head_valid;
    rsnh_pkg::cmd_t head_cmd;
    logic           pop;

    // intake: drops writes beyond the table, marks zero-direction casts
    rsnh_front #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    // two-entry queue keeps writes and casts in order
    rsnh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // execution: table, per-sphere quadratic, nearest hit search, result register
    rsnh_back #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (head_valid),
        .q_cmd     (head_cmd),
        .q_pop     (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
